[rtl/cmt_pkg.sv]
// ----------------------------------------------------------------------------
// cmt_pkg: shared types and constants of the CAN message table monitor
// Item, result, command and table entry layouts, action and mode codes.
// ----------------------------------------------------------------------------
package cmt_pkg;

  // action codes of an input item
  localparam logic [1:0] ACT_RX      = 2'd0;
  localparam logic [1:0] ACT_TICK    = 2'd1;
  localparam logic [1:0] ACT_SCAN    = 2'd2;
  localparam logic [1:0] ACT_COLLECT = 2'd3;

  // entry modes
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_TX   = 2'd1;
  localparam logic [1:0] MODE_RX   = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_FRAME  = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  // configuration register indexes
  localparam logic CFG_COUNT_LIMIT  = 1'b0;
  localparam logic CFG_AGE_INTERVAL = 1'b1;

  // start-up contents of every entry's data
  localparam logic [63:0] DATA_INIT = 64'h0000_9abc_5678_1234;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] now_ms;
    logic [10:0] frame_id;
    logic [3:0]  frame_len;
    logic [63:0] frame_bytes;
    logic        remote_request;
    logic        extended_frame;
    logic [10:0] scan_base;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] entry_id;
    logic [3:0]  entry_len;
    logic [63:0] entry_bytes;
    logic [31:0] period_ms;
    logic [31:0] unchanged_counts;
    logic [31:0] unheard_counts;
    logic [5:0]  report_count;
    logic        last;
  } out_t;

  // classified command passed from the front to the engine
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] now_ms;
    logic [10:0] frame_id;
    logic [3:0]  frame_len;
    logic [63:0] frame_bytes;
    logic [10:0] scan_base;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  len;
    logic [31:0] period;
    logic [31:0] seen;
    logic [63:0] data;
    logic [31:0] unch;
    logic [31:0] unheard;
  } entry_t;

  typedef struct packed {
    logic [3:0]  count_limit;
    logic [15:0] age_interval_ms;
  } cfg_t;

  // zero the bytes beyond the length
  function automatic logic [63:0] mask_bytes(input logic [63:0] d, input logic [3:0] len);
    logic [63:0] r;
    r = d;
    for (int k = 0; k < 8; k++) begin
      if (4'(k) >= len) begin
        r[k*8 +: 8] = 8'h00;
      end
    end
    return r;
  endfunction

  // saturating increment of the counters of the first len bytes
  function automatic logic [31:0] age_counts(input logic [31:0] p, input logic [3:0] len,
                                             input logic [3:0] limit);
    logic [31:0] r;
    r = p;
    for (int k = 0; k < 8; k++) begin
      if (4'(k) < len && p[k*4 +: 4] < limit) begin
        r[k*4 +: 4] = p[k*4 +: 4] + 4'd1;
      end
    end
    return r;
  endfunction

endpackage

[rtl/cmt_ram.sv]
// ----------------------------------------------------------------------------
// cmt_ram: generic single-write, single-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/cmt_fifo.sv]
// ----------------------------------------------------------------------------
// cmt_fifo: small register queue
// Power-of-two depth, registered storage, count-based full and empty.
// ----------------------------------------------------------------------------
module cmt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rp_r];

  // advance pointers and occupancy
  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= wdata;
    end
  end

endmodule

[rtl/cmt_front.sv]
// ----------------------------------------------------------------------------
// cmt_front: input stage of the table monitor
// Takes input beats, drops ignored frames, clamps the length and queues
// commands for the engine.
// ----------------------------------------------------------------------------
module cmt_front
  import cmt_pkg::*;
#(
  parameter int ENTRY_COUNT = 2048
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  input  in_t  in_item,
  output logic in_full,
  input  logic clearing,
  input  logic cmd_pop,
  output cmd_t cmd,
  output logic cmd_empty
);

  localparam logic [11:0] ENTRY_LIM = 12'(ENTRY_COUNT);

  logic q_full, keep, take;
  cmd_t cmd_in;

  // drop remote, extended and out-of-table frames
  always_comb begin
    keep = 1'b1;
    if (in_item.action == ACT_RX) begin
      keep = !in_item.remote_request && !in_item.extended_frame &&
             ({1'b0, in_item.frame_id} < ENTRY_LIM);
    end
    cmd_in.op          = in_item.action;
    cmd_in.now_ms      = in_item.now_ms;
    cmd_in.frame_id    = in_item.frame_id;
    cmd_in.frame_len   = (in_item.frame_len > 4'd8) ? 4'd8 : in_item.frame_len;
    cmd_in.frame_bytes = in_item.frame_bytes;
    cmd_in.scan_base   = in_item.scan_base;
  end

  assign in_full = q_full || clearing;
  assign take    = in_push && !in_full && keep;

  cmt_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(2)) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (take),
    .wdata (cmd_in),
    .full  (q_full),
    .pop   (cmd_pop),
    .rdata (cmd),
    .empty (cmd_empty)
  );

endmodule

[rtl/cmt_engine.sv]
// ----------------------------------------------------------------------------
// cmt_engine: table engine of the monitor
// Clears the table after reset, then runs receive updates, aging sweeps and
// window scans, reading each table entry and then writing it back.
// ----------------------------------------------------------------------------
module cmt_engine
  import cmt_pkg::*;
#(
  parameter int ENTRY_COUNT = 2048,
  parameter int SCAN_WINDOW = 32,
  parameter int TX_ID_LIMIT = 768
) (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  cmd_t cmd,
  input  logic cmd_empty,
  output logic cmd_pop,
  output logic clearing,
  output logic res_push,
  output out_t res,
  input  logic res_full
);

  localparam int AW = $clog2(ENTRY_COUNT);
  localparam logic [11:0] ENTRY_LIM = 12'(ENTRY_COUNT);
  localparam logic [6:0]  WIN_LIM   = 7'(SCAN_WINDOW);
  localparam logic [11:0] TX_LIM    = 12'(TX_ID_LIMIT);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_WB    = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [5:0]    win_r, win_nxt;
  logic [5:0]    n_r, n_nxt;
  logic [31:0]   age_t_r, age_t_nxt;
  cmd_t          cmd_r, cmd_nxt;

  logic          we;
  entry_t        wentry, q, init_e, upd;
  logic          emit;
  logic [1:0]    emit_kind;
  logic [11:0]   next_idx, base_idx;
  logic [6:0]    next_win;
  logic [11:0]   cur_id;
  logic [3:0]    init_len;

  cmt_ram #(.WIDTH($bits(entry_t)), .DEPTH(ENTRY_COUNT)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (addr_r),
    .wdata (wentry),
    .raddr (addr_r),
    .rdata (q)
  );

  assign clearing = (state_r == ST_CLEAR);
  assign cur_id   = 12'(addr_r);
  assign next_win = {1'b0, win_r} + 7'd1;
  assign next_idx = {1'b0, cmd_r.scan_base} + {5'd0, next_win};
  assign base_idx = {1'b0, cmd.scan_base};

  // start-up pattern of the entry at addr_r
  always_comb begin
    init_len      = {1'b0, cur_id[2:0]} + 4'd1;
    init_e.mode   = (cur_id < TX_LIM) ? MODE_TX : MODE_NONE;
    init_e.len    = init_len;
    init_e.period = (cur_id < 12'd10) ? 32'(init_len) * 32'd10 : 32'(init_len) * 32'd100;
    init_e.seen   = '0;
    init_e.data   = DATA_INIT;
    init_e.unch   = '0;
    init_e.unheard = '0;
  end

  // updated entry and emit decision for the current command
  always_comb begin
    upd       = q;
    emit      = 1'b0;
    emit_kind = KIND_FRAME;
    case (cmd_r.op)
      ACT_RX: begin
        upd.mode   = MODE_RX;
        upd.len    = cmd_r.frame_len;
        upd.period = cmd_r.now_ms - q.seen;
        upd.seen   = cmd_r.now_ms;
        for (int k = 0; k < 8; k++) begin
          if (4'(k) < cmd_r.frame_len) begin
            if (cmd_r.frame_bytes[k*8 +: 8] != q.data[k*8 +: 8]) begin
              upd.unch[k*4 +: 4] = 4'd0;
            end
            upd.data[k*8 +: 8]    = cmd_r.frame_bytes[k*8 +: 8];
            upd.unheard[k*4 +: 4] = 4'd0;
          end
        end
      end
      ACT_TICK: begin
        if (q.mode == MODE_RX) begin
          upd.unch    = age_counts(q.unch, q.len, cfg.count_limit);
          upd.unheard = age_counts(q.unheard, q.len, cfg.count_limit);
        end
      end
      ACT_SCAN: begin
        if (q.mode == MODE_TX && (cmd_r.now_ms - q.seen) >= q.period) begin
          emit             = 1'b1;
          upd.seen         = cmd_r.now_ms;
          upd.data[63:48]  = q.data[63:48] + 16'd1;
        end
      end
      default: begin
        if (q.mode == MODE_RX) begin
          emit      = 1'b1;
          emit_kind = KIND_REPORT;
          upd.mode  = MODE_NONE;
        end
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    win_nxt   = win_r;
    n_nxt     = n_r;
    age_t_nxt = age_t_r;
    cmd_nxt   = cmd_r;
    cmd_pop   = 1'b0;
    we        = 1'b0;
    wentry    = upd;
    res_push  = 1'b0;
    res       = '0;
    case (state_r)
      ST_CLEAR: begin
        we     = 1'b1;
        wentry = init_e;
        if (addr_r == AW'(ENTRY_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd;
          n_nxt   = '0;
          win_nxt = '0;
          case (cmd.op)
            ACT_RX: begin
              addr_nxt  = cmd.frame_id[AW-1:0];
              state_nxt = ST_RD;
            end
            ACT_TICK: begin
              if ((cmd.now_ms - age_t_r) > 32'(cfg.age_interval_ms)) begin
                age_t_nxt = cmd.now_ms;
                addr_nxt  = '0;
                state_nxt = ST_RD;
              end
            end
            default: begin
              if (base_idx < ENTRY_LIM) begin
                addr_nxt  = cmd.scan_base[AW-1:0];
                state_nxt = ST_RD;
              end else begin
                state_nxt = ST_DONE;
              end
            end
          endcase
        end
      end
      ST_RD: begin
        state_nxt = ST_WB;
      end
      ST_WB: begin
        if (!(emit && res_full)) begin
          we = 1'b1;
          if (emit) begin
            res_push         = 1'b1;
            res.kind         = emit_kind;
            res.entry_id     = 11'(cur_id);
            res.entry_len    = q.len;
            res.entry_bytes  = mask_bytes(q.data, q.len);
            res.period_ms    = q.period;
            res.unchanged_counts = q.unch;
            res.unheard_counts   = q.unheard;
            n_nxt            = n_r + 6'd1;
          end
          case (cmd_r.op)
            ACT_RX: begin
              state_nxt = ST_IDLE;
            end
            ACT_TICK: begin
              if (addr_r == AW'(ENTRY_COUNT - 1)) begin
                state_nxt = ST_IDLE;
              end else begin
                addr_nxt  = addr_r + 1'b1;
                state_nxt = ST_RD;
              end
            end
            default: begin
              win_nxt = next_win[5:0];
              if (next_win < WIN_LIM && next_idx < ENTRY_LIM) begin
                addr_nxt  = next_idx[AW-1:0];
                state_nxt = ST_RD;
              end else begin
                state_nxt = ST_DONE;
              end
            end
          endcase
        end
      end
      ST_DONE: begin
        if (!res_full) begin
          res_push         = 1'b1;
          res.kind         = KIND_DONE;
          res.report_count = n_r;
          res.last         = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      addr_r  <= '0;
      win_r   <= '0;
      n_r     <= '0;
      age_t_r <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      win_r   <= win_nxt;
      n_r     <= n_nxt;
      age_t_r <= age_t_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

[rtl/can_message_table_monitor.sv]
// ----------------------------------------------------------------------------
// can_message_table_monitor: CAN message table with receive, aging, transmit
// scan and collect actions.
// ----------------------------------------------------------------------------
// Input items enter through a queue port (in_push / in_full) and results
// leave through one (out_pop / out_empty); the oldest result sits on
// out_item while out_empty is low. Registers are written through cfg_valid /
// cfg_ready (always ready) with cfg_index 0 = count limit, 1 = age interval.
// After reset the table is loaded with its start-up pattern one entry per
// cycle, ENTRY_COUNT entries (2048 by default); in_full stays high meanwhile.
// Each table entry the engine touches is first read from the table, then
// updated and written back, on the single table RAM port pair. A receive
// touches one entry, a tick that ages every entry, a scan or collect up to
// SCAN_WINDOW entries and then a done result; other items touch none.
// A two-entry command queue decouples input from the engine and a
// two-entry result queue decouples the engine from the receiver; when the
// receiver stalls the engine holds on the entry it is about to emit.
// ----------------------------------------------------------------------------
module can_message_table_monitor
  import cmt_pkg::*;
#(
  parameter int ENTRY_COUNT = 2048,
  parameter int SCAN_WINDOW = 32,
  parameter int TX_ID_LIMIT = 768
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  in_t         in_item,
  output logic        in_full,
  output logic        out_empty,
  output out_t        out_item,
  input  logic        out_pop,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  cmd_t cmd;
  logic cmd_empty, cmd_pop, clearing;
  logic res_push, res_full;
  out_t res;

  assign cfg_ready = 1'b1;

  // register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_COUNT_LIMIT:  cfg_nxt.count_limit     = cfg_data[3:0];
        CFG_AGE_INTERVAL: cfg_nxt.age_interval_ms = cfg_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.count_limit     <= 4'd5;
      cfg_r.age_interval_ms <= 16'd1000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cmt_front #(.ENTRY_COUNT(ENTRY_COUNT)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .clearing  (clearing),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .cmd_empty (cmd_empty)
  );

  cmt_engine #(
    .ENTRY_COUNT (ENTRY_COUNT),
    .SCAN_WINDOW (SCAN_WINDOW),
    .TX_ID_LIMIT (TX_ID_LIMIT)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd       (cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .clearing  (clearing),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  cmt_fifo #(.WIDTH($bits(out_t)), .DEPTH(2)) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_item),
    .empty (out_empty)
  );

endmodule

[rtl/cmt_checker.sv]
// ----------------------------------------------------------------------------
// cmt_checker: port-level checks of the table monitor
// Reset behavior and result field consistency, bound to the top level.
// ----------------------------------------------------------------------------
module cmt_checker
  import cmt_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_full,
  input logic        out_empty,
  input out_t        out_item
);

  // table load blocks input right after reset
  a_full_after_reset: assert property (@(posedge clk) !rst_n |=> in_full)
    else $error("input not blocked after reset");

  // no result waits after reset
  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result present after reset");

  // done beat closes the run
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.kind == KIND_DONE) |-> (out_item.last &&
      out_item.entry_id == '0 && out_item.entry_bytes == '0))
    else $error("done beat malformed");

  // frame and report beats carry no count and no last flag
  a_entry_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.kind != KIND_DONE) |-> (!out_item.last &&
      out_item.report_count == '0 && out_item.kind != 2'd3))
    else $error("entry beat malformed");

endmodule

bind can_message_table_monitor cmt_checker u_cmt_checker (.*);
